>>> rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");

`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, expr)

`define ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

>>> rtl/tmpm_pkg.sv
// Types and constants for the three-motor PWM driver
package tmpm_pkg;

  typedef enum logic [2:0] {
    ACT_TICK      = 3'd0,
    ACT_SET_SPEED = 3'd1,
    ACT_SET_DIR   = 3'd2,
    ACT_CORRECT   = 3'd3,
    ACT_STEER     = 3'd4,
    ACT_CORR_OFF  = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    CFG_PERIOD  = 2'd0,
    CFG_CRUISE  = 2'd1,
    CFG_VARIANT = 2'd2
  } cfg_idx_t;

  localparam logic [7:0] PERIOD_RST  = 8'd200;
  localparam logic [7:0] CRUISE_RST  = 8'd110;
  localparam logic [6:0] HEADING_MAX = 7'd90;

  // heading segment bounds (heading units)
  localparam logic [6:0] SEG_A_MAX = 7'd15;
  localparam logic [6:0] SEG_B_MAX = 7'd45;
  localparam logic [6:0] SEG_C_MAX = 7'd75;

  localparam logic [5:0] FULL_SCALE = 6'd60;

  // x / 60 == (x * 17477) >> 20 for x < 15360
  localparam logic [14:0] DIV60_RECIP = 15'd17477;
  localparam int          DIV60_SHIFT = 20;

  localparam int NMOT = 3;

  typedef struct packed {
    logic [2:0]        act;
    logic [1:0]        sel;
    logic [7:0]        spd;
    logic              dbit;
    logic [10:0]       corr;
    logic [2:0][13:0]  prod;
    logic [2:0]        sdir;
  } stage_t;

  typedef struct packed {
    logic [7:0]       tick_count;
    logic [2:0][7:0]  req;
    logic [2:0][7:0]  app;
    logic [2:0]       dir;
    logic [2:0]       drv;
    logic             corr_en;
  } state_t;

endpackage

>>> rtl/tmpm_in_stage.sv
// Input register with steering factor products
module tmpm_in_stage import tmpm_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_stall,
  input  logic [2:0]   in_action,
  input  logic [1:0]   in_motor_select,
  input  logic [7:0]   in_speed_value,
  input  logic         in_direction_bit,
  input  logic signed [10:0] in_correction,
  input  logic [6:0]   in_heading,
  input  logic [7:0]   cruise,
  input  logic         variant,
  input  logic         adv,
  output logic         stg_vld,
  output stage_t       stg
);

  logic       vld_r, vld_nxt;
  stage_t     stg_r, stg_nxt;
  logic       accept;
  logic [6:0] h;
  logic [7:0] h2;
  logic [7:0] f_b, f_l, f_r;
  logic [2:0] sdir;

  assign in_stall = vld_r && !adv;
  assign accept   = in_valid && !in_stall;
  assign vld_nxt  = accept || (vld_r && !adv);

  always_comb begin
    h  = (in_heading > HEADING_MAX) ? HEADING_MAX : in_heading;
    h2 = {h, 1'b0};
    if (h <= SEG_A_MAX) begin
      f_b  = 8'(FULL_SCALE);
      f_l  = h2 + 8'd30;
      f_r  = 8'd30 - h2;
      sdir = {1'b1, ~variant, variant};
    end else if (h <= SEG_B_MAX) begin
      f_b  = 8'd90 - h2;
      f_l  = 8'(FULL_SCALE);
      f_r  = h2 - 8'd30;
      sdir = {1'b0, ~variant, variant};
    end else if (h <= SEG_C_MAX) begin
      f_b  = h2 - 8'd90;
      f_l  = 8'd150 - h2;
      f_r  = 8'(FULL_SCALE);
      sdir = {1'b0, ~variant, ~variant};
    end else begin
      f_b  = 8'(FULL_SCALE);
      f_l  = h2 - 8'd150;
      f_r  = 8'd210 - h2;
      sdir = {1'b0, variant, ~variant};
    end
    stg_nxt.act     = in_action;
    stg_nxt.sel     = in_motor_select;
    stg_nxt.spd     = in_speed_value;
    stg_nxt.dbit    = in_direction_bit;
    stg_nxt.corr    = in_correction;
    stg_nxt.prod[0] = 14'(cruise) * 14'(f_b[5:0]);
    stg_nxt.prod[1] = 14'(cruise) * 14'(f_l[5:0]);
    stg_nxt.prod[2] = 14'(cruise) * 14'(f_r[5:0]);
    stg_nxt.sdir    = sdir;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stg_r <= stg_nxt;
    end
  end

  assign stg_vld = vld_r;
  assign stg     = stg_r;

endmodule

>>> rtl/tmpm_exec.sv
// Next-state logic: PWM tick, speed and direction writes, correction, steering, correction off
module tmpm_exec import tmpm_pkg::*; (
  input  stage_t     stg,
  input  state_t     st,
  input  logic [7:0] period,
  input  logic       variant,
  output state_t     st_nxt
);

  logic [28:0]        qp [NMOT];
  logic [7:0]         q [NMOT];
  logic [2:0]         sub;
  logic signed [12:0] corr_ext;
  logic signed [12:0] req_ext [NMOT];
  logic signed [12:0] sum [NMOT];
  logic [7:0]         clamped [NMOT];
  logic [7:0]         tc1;

  always_comb begin
    corr_ext = $signed({{2{stg.corr[10]}}, stg.corr});
    sub[0]   = (st.dir[0] == variant);
    sub[1]   = (st.dir[1] == variant);
    sub[2]   = (st.dir[2] == 1'b0);
    for (int i = 0; i < NMOT; i++) begin
      qp[i]      = 29'(stg.prod[i]) * 29'(DIV60_RECIP);
      q[i]       = qp[i][DIV60_SHIFT +: 8];
      req_ext[i] = $signed({5'b0, st.req[i]});
      sum[i]     = sub[i] ? (req_ext[i] - corr_ext) : (req_ext[i] + corr_ext);
      if (sum[i] < 0) begin
        clamped[i] = 8'd0;
      end else if (sum[i] > $signed({5'b0, period})) begin
        clamped[i] = period;
      end else begin
        clamped[i] = sum[i][7:0];
      end
    end
    tc1 = st.tick_count + 8'd1;
    if (tc1 >= period) begin
      tc1 = 8'd0;
    end

    st_nxt = st;
    case (stg.act)
      ACT_TICK: begin
        for (int i = 0; i < NMOT; i++) begin
          if (st.tick_count == 8'd0) st_nxt.drv[i] = ~st.dir[i];
          if (st.tick_count == st.app[i]) st_nxt.drv[i] = st.dir[i];
        end
        st_nxt.tick_count = tc1;
      end
      ACT_SET_SPEED: begin
        for (int i = 0; i < NMOT; i++) begin
          if (stg.sel == 2'(i + 1)) begin
            st_nxt.req[i] = stg.spd;
            st_nxt.app[i] = stg.spd;
          end
        end
      end
      ACT_SET_DIR: begin
        for (int i = 0; i < NMOT; i++) begin
          if (stg.sel == 2'(i + 1)) st_nxt.dir[i] = stg.dbit;
        end
      end
      ACT_CORRECT: begin
        if (st.corr_en) begin
          for (int i = 0; i < NMOT; i++) st_nxt.app[i] = clamped[i];
        end
      end
      ACT_STEER: begin
        st_nxt.corr_en = 1'b1;
        st_nxt.dir     = stg.sdir;
        for (int i = 0; i < NMOT; i++) begin
          st_nxt.req[i] = q[i];
          st_nxt.app[i] = q[i];
        end
      end
      ACT_CORR_OFF: begin
        st_nxt.corr_en = 1'b0;
      end
      default: begin
        st_nxt = st;
      end
    endcase
  end

endmodule

>>> rtl/three_motor_pwm_with_steering_mix_core.sv
// Top level of the three-motor PWM driver with steering mix
//
// Input channel (in_*): one action word per accepted handshake (valid high,
// stall low). Actions: PWM tick, set speed, set direction, heading correction,
// steer, correction off. Result channel (out_*): one word per input word with
// the pin levels and applied duties after that action.
// Config port (cfg_*): index 0 period, 1 cruise speed, 2 robot variant;
// always ready, write while no word is in flight.
// Path: an accepted input word passes the input register, then the state/result
// register. Throughput: one word per cycle while out_stall is low; the steering
// product is formed in the input register and the divide by 60 and the state
// update after it, ahead of the state/result register.
// Reset clears all motor state and the tick count and loads period 200,
// cruise 110, variant 0.
// When out_stall holds a result, the state does not advance; one more input word
// is taken into the input register if it is empty, after which in_stall rises.
`include "assert_macros.svh"
module three_motor_pwm_with_steering_mix_core import tmpm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_action,
  input  logic [1:0]         in_motor_select,
  input  logic [7:0]         in_speed_value,
  input  logic               in_direction_bit,
  input  logic signed [10:0] in_correction,
  input  logic [6:0]         in_heading,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_drive_back,
  output logic               out_drive_left,
  output logic               out_drive_right,
  output logic               out_dir_back,
  output logic               out_dir_left,
  output logic               out_dir_right,
  output logic [7:0]         out_applied_back,
  output logic [7:0]         out_applied_left,
  output logic [7:0]         out_applied_right,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_data
);

  logic [7:0] period_lim_r;
  logic [7:0] cruise_r;
  logic       variant_r;
  logic       out_vld_r, out_vld_nxt;
  logic       adv;
  logic       stg_vld;
  stage_t     stg;
  state_t     st_r, st_nxt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_lim_r <= PERIOD_RST;
      cruise_r     <= CRUISE_RST;
      variant_r    <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PERIOD:  period_lim_r <= cfg_data;
        CFG_CRUISE:  cruise_r     <= cfg_data;
        CFG_VARIANT: variant_r    <= cfg_data[0];
        default: begin
          variant_r <= variant_r;
        end
      endcase
    end
  end

  assign adv         = stg_vld && (!out_vld_r || !out_stall);
  assign out_vld_nxt = adv || (out_vld_r && out_stall);

  tmpm_in_stage u_in_stage (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_motor_select  (in_motor_select),
    .in_speed_value   (in_speed_value),
    .in_direction_bit (in_direction_bit),
    .in_correction    (in_correction),
    .in_heading       (in_heading),
    .cruise           (cruise_r),
    .variant          (variant_r),
    .adv              (adv),
    .stg_vld          (stg_vld),
    .stg              (stg)
  );

  tmpm_exec u_exec (
    .stg     (stg),
    .st      (st_r),
    .period  (period_lim_r),
    .variant (variant_r),
    .st_nxt  (st_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= '0;
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
      if (adv) begin
        st_r <= st_nxt;
      end
    end
  end

  // result word is the motor state itself; it only moves on adv
  assign out_valid         = out_vld_r;
  assign out_drive_back    = st_r.drv[0];
  assign out_drive_left    = st_r.drv[1];
  assign out_drive_right   = st_r.drv[2];
  assign out_dir_back      = st_r.dir[0];
  assign out_dir_left      = st_r.dir[1];
  assign out_dir_right     = st_r.dir[2];
  assign out_applied_back  = st_r.app[0];
  assign out_applied_left  = st_r.app[1];
  assign out_applied_right = st_r.app[2];

  `ASSERT_NEXT(a_tick_wraps, adv && (stg.act == ACT_TICK), (st_r.tick_count == 8'd0) || (st_r.tick_count < $past(period_lim_r)))
  `ASSERT_NEXT(a_corr_clamped, adv && (stg.act == ACT_CORRECT) && st_r.corr_en, (st_r.app[0] <= $past(period_lim_r)) && (st_r.app[1] <= $past(period_lim_r)) && (st_r.app[2] <= $past(period_lim_r)))
  `ASSERT_NEXT(a_steer_sets, adv && (stg.act == ACT_STEER), st_r.corr_en && (st_r.app == st_r.req) && out_vld_r)

endmodule
